[rtl/tsth_pkg.sv]
// Shared types, codes and helpers for the timestamp triple histogram.
// Holds the sequencer state type, command and register codes, the bin compare and the saturating increment.
// No dependencies; every rtl file refers to it by scoped names.
package tsth_pkg;

  localparam int TIME_W  = 32;
  localparam int INDEX_W = 5;
  localparam int FUNC_W  = 2;
  localparam int CFGI_W  = 2;
  // Step counter of the reciprocal division, which multiplies the two halves of the constant in turn
  localparam int STEP_W  = 1;

  // Command codes carried in the input tuser
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_START_TIME = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_END_TIME   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_FINE_BINS  = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_LIST_MODE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EDGE,
    ST_LOAD0,
    ST_WALK,
    ST_CWRITE,
    ST_READ,
    ST_DONE
  } state_t;

  // Time falls in a bin: above the lower edge, below (or at) the upper edge
  function automatic logic in_bin(input logic [TIME_W-1:0] t,
                                  input logic [TIME_W-1:0] lo,
                                  input logic [TIME_W-1:0] hi,
                                  input logic              excl);
    logic upper;
    upper  = excl ? (t < hi) : (t <= hi);
    in_bin = upper && (t > lo);
  endfunction

  // Saturating increment of one counter
  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v,
                                                input logic              inc);
    sat_inc = (inc && (v != '1)) ? v + 1'b1 : v;
  endfunction

endpackage

[rtl/timestamp_triple_histogram_unit.sv]
// Top level of the timestamp triple histogram: sequencer, edge memory and counter memory.
// Depends on tsth_pkg for codes, the state type, the bin compare and the saturating increment.
//
// One command beat gives exactly one result beat. A read presents its address on
// acceptance, then passes the read and done states to the result register. A sample
// loads the lowest edge and walks the bin edges (up to bins), with one read-modify-write
// of the counter memory for each counter update (at most two); the single read port of
// the edge memory supplies one upper edge per cycle except while a counter is written.
// A clear divides the window by the bin count through a reciprocal multiply split in
// two halves, then writes bins+1 entries of the edge memory. Counters and edges are
// cleared at once through per-entry valid bits, so no clearing pass follows reset.
// The result register frees the input side: a new command is taken while the last
// result waits on the output.
module timestamp_triple_histogram_unit #(
  parameter int BASE_BINS = 10
) (
  input  logic         clk,
  input  logic         rst,
  // Command beats
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] change_time, [63:32] delete_time, [95:64] create_time, [100:96] bin_index
  input  logic [103:0] s_tdata,
  // [1:0] func
  input  logic [1:0]   s_tuser,
  // Result beats
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] bin_edge, [63:32] change_count, [95:64] delete_count,
  // [127:96] create_count, [128] create_seen
  output logic [135:0] m_tdata,
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int TW        = tsth_pkg::TIME_W;
  localparam int MAX_SLOTS = 2 * BASE_BINS + 1;
  localparam int SW        = $clog2(MAX_SLOTS);
  localparam int CW        = (SW > tsth_pkg::INDEX_W) ? SW : tsth_pkg::INDEX_W;
  localparam int CNT_W     = 3 * TW;

  // Reciprocal of BASE_BINS, exact for every 32-bit dividend; the doubled bin
  // count takes one more bit of shift
  localparam int DIV_L  = $clog2(BASE_BINS);
  localparam int RHALF  = 17;
  localparam int PROD_W = 2 * TW + DIV_L + 1;
  localparam logic [2*RHALF-1:0] RECIP =
    (2*RHALF)'((64'd1 << (TW + DIV_L)) / 64'(BASE_BINS) + 64'd1);
  localparam logic [RHALF-1:0] RECIP_LO = RECIP[RHALF-1:0];
  localparam logic [RHALF-1:0] RECIP_HI = RECIP[2*RHALF-1:RHALF];

  // Configuration registers
  logic [TW-1:0] start_time;
  logic [TW-1:0] end_time;
  logic          fine_bins;
  logic          list_mode;

  // Memories and their valid bits
  logic [TW-1:0]    edge_mem [MAX_SLOTS];
  logic [CNT_W-1:0] cnt_mem  [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] edge_vld;
  logic [MAX_SLOTS-1:0] cnt_vld;
  logic [TW-1:0]    edge_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SW-1:0]    edge_addr_q;
  logic [SW-1:0]    cnt_addr_q;
  logic [TW-1:0]    edge_rd;
  logic [CNT_W-1:0] cnt_rd;

  // Memory port controls
  logic [SW-1:0]    edge_raddr;
  logic [SW-1:0]    cnt_raddr;
  logic             edge_we;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wdata;

  // Sequencer
  tsth_pkg::state_t state, state_next;
  logic [SW-1:0]    slot;
  logic [SW-1:0]    n_bins;
  logic             accept;
  logic [1:0]       func_in;
  logic [TW-1:0]    change_in, delete_in, create_in;
  logic [tsth_pkg::INDEX_W-1:0] index_in;
  logic             idx_ok;
  logic             out_free;

  // Divider and edge accumulator
  logic [TW-1:0]               quo;
  logic [TW+RHALF-1:0]         mul;
  logic [TW+RHALF-1:0]         part;
  logic [PROD_W-1:0]           prod_sum;
  logic [TW-1:0]               q_base;
  logic [tsth_pkg::STEP_W-1:0] step;
  logic [TW-1:0]               acc;

  // Sample walk
  logic [TW-1:0] chg_t, del_t, cre_t;
  logic          cre_pend;
  logic [TW-1:0] lo;
  logic          hit_d, hit_cr, hit_c;
  logic          inc_del, inc_cre, inc_chg, fin;
  logic          any_create;
  logic          last_slot;

  // Read result
  logic          rd_ok;
  logic [TW-1:0] res_edge, res_chg, res_del, res_cre;

  assign accept    = s_tvalid && s_tready;
  assign func_in   = s_tuser[1:0];
  assign change_in = s_tdata[31:0];
  assign delete_in = s_tdata[63:32];
  assign create_in = s_tdata[95:64];
  assign index_in  = s_tdata[100:96];
  assign n_bins    = fine_bins ? SW'(2 * BASE_BINS) : SW'(BASE_BINS);
  assign idx_ok    = CW'(index_in) <= CW'(n_bins);
  assign out_free  = !m_tvalid || m_tready;
  assign last_slot = (slot == n_bins);
  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= '0;
      fine_bins  <= 1'b0;
      list_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsth_pkg::CFG_START_TIME: start_time <= cfg_data;
        tsth_pkg::CFG_END_TIME:   end_time   <= cfg_data;
        tsth_pkg::CFG_FINE_BINS:  fine_bins  <= cfg_data[0];
        tsth_pkg::CFG_LIST_MODE:  list_mode  <= cfg_data[0];
      endcase
    end
  end

  // Edge memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[slot] <= acc;
    end
    edge_q      <= edge_mem[edge_raddr];
    edge_addr_q <= edge_raddr;
  end

  // Counter memory: change, delete, create counts side by side
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[slot] <= cnt_wdata;
    end
    cnt_q      <= cnt_mem[cnt_raddr];
    cnt_addr_q <= cnt_raddr;
  end

  // Entries not written since the last clear read as zero
  assign edge_rd = edge_vld[edge_addr_q] ? edge_q : '0;
  assign cnt_rd  = cnt_vld[cnt_addr_q] ? cnt_q : '0;

  // Bin compares against the lower edge register and the edge just read
  assign hit_d  = tsth_pkg::in_bin(del_t, lo, edge_rd, list_mode);
  assign hit_cr = cre_pend && tsth_pkg::in_bin(cre_t, lo, edge_rd, list_mode);
  assign hit_c  = tsth_pkg::in_bin(chg_t, lo, edge_rd, list_mode);

  // Reciprocal multiply: low half of the constant first, high half second
  assign mul      = (TW+RHALF)'(quo) * (TW+RHALF)'(step[0] ? RECIP_HI : RECIP_LO);
  assign prod_sum = PROD_W'({mul, {RHALF{1'b0}}}) + PROD_W'(part);
  assign q_base   = prod_sum[TW+DIV_L +: TW];

  // Saturating update of the counters read for this slot
  assign cnt_wdata = {tsth_pkg::sat_inc(cnt_rd[3*TW-1:2*TW], inc_cre),
                      tsth_pkg::sat_inc(cnt_rd[2*TW-1:TW],   inc_del),
                      tsth_pkg::sat_inc(cnt_rd[TW-1:0],      inc_chg)};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tsth_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func_in)
            tsth_pkg::FUNC_CLEAR: state_next = tsth_pkg::ST_DIV;
            tsth_pkg::FUNC_ADD: begin
              state_next = (!list_mode && change_in == '0) ? tsth_pkg::ST_DONE
                                                           : tsth_pkg::ST_LOAD0;
            end
            tsth_pkg::FUNC_READ: state_next = tsth_pkg::ST_READ;
            tsth_pkg::FUNC_NOP:  state_next = tsth_pkg::ST_DONE;
          endcase
        end
      end
      tsth_pkg::ST_DIV:   if (step == '1) state_next = tsth_pkg::ST_EDGE;
      tsth_pkg::ST_EDGE:  if (last_slot) state_next = tsth_pkg::ST_DONE;
      tsth_pkg::ST_LOAD0: state_next = tsth_pkg::ST_WALK;
      tsth_pkg::ST_WALK: begin
        if (hit_d || hit_cr || hit_c) begin
          state_next = tsth_pkg::ST_CWRITE;
        end else if (last_slot) begin
          state_next = tsth_pkg::ST_DONE;
        end
      end
      tsth_pkg::ST_CWRITE: begin
        state_next = (fin || last_slot) ? tsth_pkg::ST_DONE : tsth_pkg::ST_WALK;
      end
      tsth_pkg::ST_READ: state_next = tsth_pkg::ST_DONE;
      tsth_pkg::ST_DONE: if (out_free) state_next = tsth_pkg::ST_IDLE;
      default:           state_next = tsth_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory port controls
  always_comb begin
    s_tready   = 1'b0;
    edge_raddr = '0;
    cnt_raddr  = slot;
    edge_we    = 1'b0;
    cnt_we     = 1'b0;
    unique case (state)
      tsth_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (func_in == tsth_pkg::FUNC_READ && idx_ok) begin
          edge_raddr = SW'(index_in);
          cnt_raddr  = SW'(index_in);
        end
      end
      tsth_pkg::ST_EDGE:  edge_we = 1'b1;
      tsth_pkg::ST_LOAD0: edge_raddr = SW'(1);
      tsth_pkg::ST_WALK:  edge_raddr = last_slot ? slot : SW'(slot + 1'b1);
      tsth_pkg::ST_CWRITE: begin
        cnt_we     = 1'b1;
        edge_raddr = last_slot ? slot : SW'(slot + 1'b1);
      end
      default: begin
        edge_raddr = '0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsth_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Valid bits and the create flag: clear drops everything at once
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_vld   <= '0;
      cnt_vld    <= '0;
      any_create <= 1'b0;
    end else begin
      if (accept && func_in == tsth_pkg::FUNC_CLEAR) begin
        edge_vld   <= '0;
        cnt_vld    <= '0;
        any_create <= 1'b0;
      end
      if (edge_we) edge_vld[slot] <= 1'b1;
      if (cnt_we) cnt_vld[slot] <= 1'b1;
      if (state == tsth_pkg::ST_WALK && !hit_d && hit_cr) any_create <= 1'b1;
    end
  end

  // Datapath registers for division, edge fill, sample walk and read
  always_ff @(posedge clk) begin
    unique case (state)
      tsth_pkg::ST_IDLE: begin
        if (accept) begin
          quo      <= end_time - start_time;
          step     <= '0;
          chg_t    <= change_in;
          del_t    <= delete_in;
          cre_t    <= create_in;
          cre_pend <= create_in != '0;
          rd_ok    <= idx_ok;
          res_edge <= '0;
          res_chg  <= '0;
          res_del  <= '0;
          res_cre  <= '0;
        end
      end
      tsth_pkg::ST_DIV: begin
        if (step == '0) begin
          part <= mul;
        end else begin
          quo <= fine_bins ? {1'b0, q_base[TW-1:1]} : q_base;
        end
        step <= tsth_pkg::STEP_W'(step + 1'b1);
        acc  <= start_time;
        slot <= '0;
      end
      tsth_pkg::ST_EDGE: begin
        acc  <= acc + quo;
        slot <= SW'(slot + 1'b1);
      end
      tsth_pkg::ST_LOAD0: begin
        lo   <= edge_rd;
        slot <= SW'(1);
      end
      tsth_pkg::ST_WALK: begin
        lo <= edge_rd;
        if (hit_d) begin
          inc_del <= 1'b1;
          inc_cre <= 1'b0;
          inc_chg <= 1'b0;
          fin     <= 1'b1;
        end else if (hit_cr) begin
          inc_del  <= 1'b0;
          inc_cre  <= 1'b1;
          inc_chg  <= hit_c;
          fin      <= hit_c;
          cre_pend <= 1'b0;
        end else if (hit_c) begin
          inc_del <= 1'b0;
          inc_cre <= 1'b0;
          inc_chg <= 1'b1;
          fin     <= 1'b1;
        end else if (!last_slot) begin
          slot <= SW'(slot + 1'b1);
        end
      end
      tsth_pkg::ST_CWRITE: begin
        if (!fin && !last_slot) begin
          slot <= SW'(slot + 1'b1);
        end
      end
      tsth_pkg::ST_READ: begin
        res_edge <= rd_ok ? edge_rd : '0;
        res_chg  <= rd_ok ? cnt_rd[TW-1:0] : '0;
        res_del  <= rd_ok ? cnt_rd[2*TW-1:TW] : '0;
        res_cre  <= rd_ok ? cnt_rd[3*TW-1:2*TW] : '0;
      end
      default: begin
        lo <= lo;
      end
    endcase
  end

  // Result register: load when done and the output side is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == tsth_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tsth_pkg::ST_DONE && out_free) begin
      m_tdata <= {7'd0, any_create, res_cre, res_del, res_chg, res_edge};
    end
  end

endmodule
